// ===== hdl/npt_pkg.sv =====
// Shared constants, types and state encoding for the next-prime search block.
package npt_pkg;

   localparam int VALUE_BITS = 31;
   localparam int CNT_BITS = $clog2(VALUE_BITS);

   localparam logic [VALUE_BITS-1:0] VALUE_MASK = {VALUE_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] FIRST_DIVISOR = VALUE_BITS'(2);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(VALUE_BITS - 1);

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      value_type quotient;
      value_type remainder;
   } npt_div_result_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_START,
      S_WAIT
   } npt_state_type;

endpackage

// ===== hdl/npt_divider.sv =====
// Shared restoring divider: one quotient bit per cycle, gives quotient and remainder.
module npt_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  npt_pkg::value_type          dividend,
   input  npt_pkg::value_type          divisor,
   output logic                        done,
   output npt_pkg::npt_div_result_type result
);
   import npt_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   value_type           work_ff, work_in;
   value_type           rem_ff, rem_in;
   value_type           dsor_ff, dsor_in;

   logic [VALUE_BITS:0] shifted;
   logic [VALUE_BITS:0] diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      dsor_in  = dsor_ff;
      // Bring down the next dividend bit and try to subtract the divisor.
      shifted  = {rem_ff, work_ff[VALUE_BITS-1]};
      diff     = shifted - {1'b0, dsor_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = LAST_STEP;
         work_in  = dividend;
         rem_in   = '0;
         dsor_in  = divisor;
      end else if (busy_ff) begin
         // The dividend shifts out at the top while quotient bits fill in below.
         if (!diff[VALUE_BITS]) begin
            rem_in  = diff[VALUE_BITS-1:0];
            work_in = {work_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted[VALUE_BITS-1:0];
            work_in = {work_ff[VALUE_BITS-2:0], 1'b0};
         end
         count_in = count_ff - CNT_BITS'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      dsor_ff  <= dsor_in;
   end

   assign done             = done_ff;
   assign result.quotient  = work_ff;
   assign result.remainder = rem_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_start_then_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not begin after start");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("divider done without a finished division");

endmodule

// ===== hdl/next_prime_trial_division_top.sv =====
// Next-prime search: sequencer that drives trial divisions through the shared divider.
// Each trial division starts the bit-serial divider in S_START and waits in S_WAIT for done.
// busy falls as the result strobe rises, so the next word can be accepted at the edge that
// takes the result; no word is taken while a search runs. The receiver cannot stall the result.
// Synchronous active-high reset returns to idle with no result pending.
module next_prime_trial_division_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  npt_pkg::value_type req_start_value,
   output logic               rsp_valid,
   output npt_pkg::value_type rsp_prime_found
);
   import npt_pkg::*;

   npt_state_type      state_ff, state_in;
   value_type          cand_ff, cand_in;
   value_type          divisor_ff, divisor_in;
   logic               rsp_valid_ff, rsp_valid_in;
   value_type          rsp_prime_ff, rsp_prime_in;

   logic               div_start;
   logic               div_done;
   npt_div_result_type div_result;

   npt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .result   (div_result)
   );

   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      divisor_in   = divisor_ff;
      rsp_valid_in = 1'b0;
      rsp_prime_in = rsp_prime_ff;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cand_in    = req_start_value;
               divisor_in = FIRST_DIVISOR;
               state_in   = S_START;
            end
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               if (divisor_ff > div_result.quotient) begin
                  // Divisor passed the square root: the candidate is prime.
                  rsp_valid_in = 1'b1;
                  rsp_prime_in = cand_ff;
                  state_in     = S_IDLE;
               end else if (div_result.remainder == '0) begin
                  if (cand_ff == VALUE_MASK) begin
                     // The search ran off the top and wraps to zero.
                     rsp_valid_in = 1'b1;
                     rsp_prime_in = '0;
                     state_in     = S_IDLE;
                  end else begin
                     cand_in    = cand_ff + VALUE_BITS'(1);
                     divisor_in = FIRST_DIVISOR;
                     state_in   = S_START;
                  end
               end else begin
                  divisor_in = divisor_ff + VALUE_BITS'(1);
                  state_in   = S_START;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff      <= cand_in;
      divisor_ff   <= divisor_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_found = rsp_prime_ff;

   a_accept_starts_trial: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_START))
      else $error("accepted word did not start a trial division");

   a_result_from_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == S_WAIT && $past(div_done)))
      else $error("result issued outside a finished division");

   a_divisor_at_least_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (divisor_ff >= FIRST_DIVISOR))
      else $error("trial divisor below two");

endmodule

// ===== test/tb_next_prime_trial_division_top.sv =====
// Self-checking testbench for the next-prime trial-division block.
module tb_next_prime_trial_division_top;
   import npt_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 7;
   // The slowest word is the top value.
   localparam int QUIET_LIMIT = 6_000_000;
   localparam int DRAIN_CYCLES = 100;
   localparam int DIRECTED_ROWS = 17;
   localparam int PHASES = 3;

   typedef struct packed {
      value_type start_value;
      logic      typed;
      value_type prime_found;
   } npt_row_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      start;
   logic      busy;
   value_type req_start_value;
   logic      rsp_valid;
   value_type rsp_prime_found;

   value_type pending_primes[$];
   int        mismatch_count = 0;
   int        quiet_cycles = 0;

   // Rows with typed = 1 carry an answer that can be read off directly.
   npt_row_type directed_rows [DIRECTED_ROWS] = '{
      '{31'd0,          1'b1, 31'd0},
      '{31'd1,          1'b1, 31'd1},
      '{31'd2,          1'b1, 31'd2},
      '{31'd3,          1'b1, 31'd3},
      '{31'd4,          1'b1, 31'd5},
      '{31'd8,          1'b1, 31'd11},
      '{31'h7FFF_FFFF,  1'b1, 31'h7FFF_FFFF},
      '{31'd24,         1'b0, 31'd0},
      '{31'd25,         1'b0, 31'd0},
      '{31'd49,         1'b0, 31'd0},
      '{31'd90,         1'b0, 31'd0},
      '{31'd114,        1'b0, 31'd0},
      '{31'd121,        1'b0, 31'd0},
      '{31'd32767,      1'b0, 31'd0},
      '{31'd65521,      1'b0, 31'd0},
      '{31'd65536,      1'b0, 31'd0},
      '{31'd1000000,    1'b0, 31'd0}
   };

   int idle_percent [PHASES] = '{0, 48, 38};
   int phase_words [PHASES] = '{34, 33, 33};

   next_prime_trial_division_top DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_start_value (req_start_value),
      .rsp_valid       (rsp_valid),
      .rsp_prime_found (rsp_prime_found)
   );

   always #CLOCK_HALF clock = ~clock;

   // Smallest prime at least the given value; zero and one count as prime.
   function automatic value_type next_prime_at_least(input value_type from);
      longint unsigned cand;
      longint unsigned divisor;
      bit composite;
      bit done;
      cand = from;
      done = 1'b0;
      while (!done) begin
         composite = 1'b0;
         for (divisor = 2; divisor <= cand / divisor && !composite; divisor++) begin
            if (cand % divisor == 0) composite = 1'b1;
         end
         if (!composite) begin
            done = 1'b1;
         end else if (cand == VALUE_MASK) begin
            cand = 0;
            done = 1'b1;
         end else begin
            cand++;
         end
      end
      return value_type'(cand);
   endfunction

   task automatic send_word(input value_type value, input bit typed,
                            input value_type typed_prime, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_start_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_primes.push_back(typed ? typed_prime : next_prime_at_least(value));
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_primes.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_primes.size() == 0) begin
               $display("%0t: unexpected result: expected none, got %0d",
                        $time, rsp_prime_found);
               mismatch_count++;
            end else begin
               if (rsp_prime_found !== pending_primes[0]) begin
                  $display("%0t: prime_found mismatch: expected %0d, got %0d",
                           $time, pending_primes[0], rsp_prime_found);
                  mismatch_count++;
               end
               void'(pending_primes.pop_front());
            end
         end
         if (rsp_valid || (start && !busy)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_primes.size());
            $display("[next_prime_trial_division_top] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int width;
      value_type value;
      reset = 1'b1;
      start = 1'b0;
      req_start_value = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].start_value, directed_rows[i].typed,
                   directed_rows[i].prime_found, 0);
      end

      // Random words stay small so that the run time is dominated by the top value.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         for (int n = 0; n < phase_words[phase]; n++) begin
            width = $urandom_range(18, 1);
            value = value_type'($urandom() & ((32'd1 << width) - 1));
            send_word(value, 1'b0, '0, idle_percent[phase]);
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_primes.size() == 0) begin
         $display("[next_prime_trial_division_top] OK");
      end else begin
         $display("[next_prime_trial_division_top] ERROR");
      end
      $finish;
   end

endmodule
